FILE: design/mfb_pkg.sv
// Shared types and constants for the monochrome framebuffer page refresh block.
`default_nettype none

package mfb_pkg;

	// Panel geometry.
	localparam int DISPLAY_COLUMNS = 128;
	localparam int DISPLAY_ROWS    = 64;
	localparam int HALF_WIDTH      = 64;

	localparam int PAGE_COUNT = (DISPLAY_ROWS + 7) / 8;
	localparam int COL_W      = $clog2(DISPLAY_COLUMNS);
	localparam int ROW_W      = $clog2(DISPLAY_ROWS);
	localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int ADDR_W     = COL_W + PAGE_W;
	localparam int MEM_DEPTH  = 1 << ADDR_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Clip limits at the width of a sum of two 8-bit fields.
	localparam logic [8:0] COLS_9 = 9'(DISPLAY_COLUMNS);
	localparam logic [8:0] ROWS_9 = 9'(DISPLAY_ROWS);

	// Controller command bytes.
	localparam logic [7:0] CMD_SET_PAGE   = 8'b1011_1000;
	localparam logic [7:0] CMD_SET_COLUMN = 8'b0100_0000;
	localparam logic [7:0] CMD_DISPLAY    = 8'b0011_1110;

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_FILL    = 2'd1,
		FUNC_REFRESH = 2'd2,
		FUNC_DISPLAY = 2'd3
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] rect_rows;
		logic [7:0] rect_cols;
		logic       pixel_value;
		logic       display_on;
	} item_t;

	typedef struct packed {
		logic       chip_left;
		logic       chip_right;
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last_write;
	} result_t;

	// Classified job handed from the front to the back.
	typedef struct packed {
		func_t             kind;
		logic [COL_W-1:0]  col_lo;
		logic [COL_W-1:0]  col_hi;
		logic [PAGE_W-1:0] page_lo;
		logic [PAGE_W-1:0] page_hi;
		logic [ROW_W-1:0]  row_lo;
		logic [ROW_W-1:0]  row_hi;
		logic              value;
		logic              display_on;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_sts_t;

	typedef struct packed {
		logic ready;
	} back_sts_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_FILL,
		BK_REF_PAGE,
		BK_REF_COL,
		BK_REF_DATA
	} back_state_t;

endpackage

`default_nettype wire

FILE: design/mfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/mfb_front.sv
// Front end: accepts words, clips rectangles and pushes jobs into the queue.
`default_nettype none

module mfb_front
	import mfb_pkg::*;
(
	input  wire logic       start,
	input  wire item_t      item,
	input  wire queue_sts_t q_sts,
	input  wire back_sts_t  b_sts,
	output logic            busy,
	output logic            push,
	output job_t            job
);

	logic [8:0] x_end;
	logic [8:0] y_end;
	logic [8:0] x_last;
	logic [8:0] y_last;
	logic       empty_rect;

	// Hold off while the store is being swept after reset or the queue is full.
	assign busy = q_sts.full || !b_sts.ready;

	// Clip the rectangle to the panel; ends are inclusive.
	always_comb begin
		x_end  = {1'b0, item.pos_x} + {1'b0, item.rect_cols};
		y_end  = {1'b0, item.pos_y} + {1'b0, item.rect_rows};
		x_last = (x_end > COLS_9) ? (COLS_9 - 9'd1) : (x_end - 9'd1);
		y_last = (y_end > ROWS_9) ? (ROWS_9 - 9'd1) : (y_end - 9'd1);
		empty_rect = (item.rect_cols == 8'd0) || (item.rect_rows == 8'd0) ||
			({1'b0, item.pos_x} >= COLS_9) || ({1'b0, item.pos_y} >= ROWS_9);
	end

	// Build the job word.
	always_comb begin
		job.kind       = item.func;
		job.col_lo     = COL_W'(item.pos_x);
		job.col_hi     = COL_W'(x_last);
		job.row_lo     = ROW_W'(item.pos_y);
		job.row_hi     = ROW_W'(y_last);
		job.page_lo    = PAGE_W'(item.pos_y >> 3);
		job.page_hi    = PAGE_W'(y_last >> 3);
		job.value      = item.pixel_value;
		job.display_on = item.display_on;
	end

	// A rectangle that touches no pixel is accepted and dropped here.
	assign push = start && !busy && !((item.func == FUNC_FILL) && empty_rect);

endmodule

`default_nettype wire

FILE: design/mfb_queue.sv
// Short job queue between the front and back ends.
`default_nettype none

module mfb_queue
	import mfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire job_t       push_job,
	input  wire logic       pop,
	output job_t            head,
	output queue_sts_t      sts
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head      = slot_q[rd_ptr_q];
	assign sts.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign sts.empty = (count_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/mfb_back.sv
// Back end: clears and fills the pixel store and drives the controller writes.
`default_nettype none

module mfb_back
	import mfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire job_t       head,
	input  wire queue_sts_t q_sts,
	output logic            pop,
	output back_sts_t       sts,
	output logic            result_valid,
	output result_t         result
);

	back_state_t       state_q, state_d;
	job_t              job_q;
	logic              init_done_q;
	logic [ADDR_W-1:0] clr_q;
	logic [COL_W-1:0]  col_q;
	logic [PAGE_W-1:0] page_q;
	logic [COL_W-1:0]  ref_col_q;
	logic [PAGE_W-1:0] ref_page_q;
	logic              fill_vld_s1;
	logic [ADDR_W-1:0] fill_addr_s1;
	logic [7:0]        fill_mask_s1;
	logic              fill_val_s1;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic [7:0]        mask;
	logic              res_vld_d;
	result_t           res_d;
	logic              ref_right;
	logic [5:0]        ref_local;

	// Pixel store: one byte per column and page, bit i is row page*8+i.
	mfb_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign sts.ready = init_done_q;

	// Row mask of the current fill page.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[i] = ({page_q, 3'(i)} >= (PAGE_W + 3)'(job_q.row_lo)) &&
				({page_q, 3'(i)} <= (PAGE_W + 3)'(job_q.row_hi));
		end
	end

	// Half select and column within the half for the refresh pointer.
	always_comb begin
		ref_right = (ref_col_q >= COL_W'(HALF_WIDTH));
		ref_local = ref_right ? 6'(ref_col_q - COL_W'(HALF_WIDTH)) : 6'(ref_col_q);
	end

	// Store write port: sweep zeroes, otherwise the fill read-modify-write.
	always_comb begin
		if (state_q == BK_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = fill_vld_s1;
			wr_addr = fill_addr_s1;
			wr_data = fill_val_s1 ? (rd_data | fill_mask_s1) : (rd_data & ~fill_mask_s1);
		end
	end

	// Next state, reads and results.
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {col_q, page_q};
		res_vld_d = 1'b0;
		res_d     = '0;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == '1) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_sts.empty) begin
					pop = 1'b1;
					case (head.kind)
						FUNC_CLEAR:   state_d = BK_CLEAR;
						FUNC_FILL:    state_d = BK_FILL;
						FUNC_REFRESH: state_d = BK_REF_PAGE;
						FUNC_DISPLAY: begin
							res_vld_d        = 1'b1;
							res_d.chip_left  = 1'b1;
							res_d.chip_right = 1'b1;
							res_d.bus_byte   = CMD_DISPLAY | {7'd0, head.display_on};
							res_d.last_write = 1'b1;
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_FILL: begin
				rd_en = 1'b1;
				if ((page_q == job_q.page_hi) && (col_q == job_q.col_hi)) begin
					state_d = BK_IDLE;
				end
			end
			BK_REF_PAGE: begin
				rd_en            = 1'b1;
				rd_addr          = {ref_col_q, ref_page_q};
				res_vld_d        = 1'b1;
				res_d.chip_left  = !ref_right;
				res_d.chip_right = ref_right;
				res_d.bus_byte   = CMD_SET_PAGE | (8'(ref_page_q) & 8'd7);
				state_d          = BK_REF_COL;
			end
			BK_REF_COL: begin
				res_vld_d        = 1'b1;
				res_d.chip_left  = !ref_right;
				res_d.chip_right = ref_right;
				res_d.bus_byte   = CMD_SET_COLUMN | {2'b00, ref_local};
				state_d          = BK_REF_DATA;
			end
			BK_REF_DATA: begin
				res_vld_d        = 1'b1;
				res_d.chip_left  = !ref_right;
				res_d.chip_right = ref_right;
				res_d.is_data    = 1'b1;
				res_d.bus_byte   = rd_data;
				res_d.last_write = 1'b1;
				state_d          = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep counter, refresh pointer, fill valid and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_done_q  <= 1'b0;
			clr_q        <= '0;
			ref_col_q    <= '0;
			ref_page_q   <= '0;
			fill_vld_s1  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= res_vld_d;
			fill_vld_s1  <= (state_q == BK_FILL);
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) begin
					init_done_q <= 1'b1;
				end
			end
			if (state_q == BK_REF_DATA) begin
				if (ref_page_q == PAGE_W'(PAGE_COUNT - 1)) begin
					ref_page_q <= '0;
					ref_col_q  <= (ref_col_q == COL_W'(DISPLAY_COLUMNS - 1)) ? '0 :
						ref_col_q + 1'b1;
				end else begin
					ref_page_q <= ref_page_q + 1'b1;
				end
			end
		end
	end

	// Job word, fill walk (page first), write-back stage and result data; no reset needed.
	always_ff @(posedge clk) begin
		result <= res_d;
		if (pop) begin
			job_q  <= head;
			col_q  <= head.col_lo;
			page_q <= head.page_lo;
		end else if (state_q == BK_FILL) begin
			if (page_q == job_q.page_hi) begin
				page_q <= job_q.page_lo;
				col_q  <= col_q + 1'b1;
			end else begin
				page_q <= page_q + 1'b1;
			end
		end
		fill_addr_s1 <= {col_q, page_q};
		fill_mask_s1 <= mask;
		fill_val_s1  <= job_q.value;
	end

endmodule

`default_nettype wire

FILE: design/mono_framebuffer_page_refresh.sv
// Top level of the monochrome framebuffer page refresh block.
// After reset a sweep zeroes all 1024 entries of the pixel store, with busy high throughout.
// A refresh word leaves the queue, then gives three writes back to back: set page, set column, data.
// A display word gives its one write through the queue and the result register; a clear word sweeps the store again.
// A rectangle is filled one column-page per cycle, read-modify-write through the store's one write port.
// A two-word queue lets new words be accepted while the back end works; results cannot stall.
`default_nettype none

module mono_framebuffer_page_refresh
	import mfb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire item_t item,
	output logic      result_valid,
	output result_t   result
);

	logic       push;
	logic       pop;
	job_t       push_job;
	job_t       head;
	queue_sts_t q_sts;
	back_sts_t  b_sts;

	mfb_front u_front (
		.start (start),
		.item  (item),
		.q_sts (q_sts),
		.b_sts (b_sts),
		.busy  (busy),
		.push  (push),
		.job   (push_job)
	);

	mfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.sts      (q_sts)
	);

	mfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_sts        (q_sts),
		.pop          (pop),
		.sts          (b_sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: design/mfb_checker.sv
// Port-level checker for the framebuffer block, bound to the top level.
`default_nettype none

module mfb_checker
	import mfb_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire result_t result
);

	// Every write selects at least one controller half.
	a_chip_sel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.chip_left || result.chip_right))
		else $error("write with no controller selected");

	// A data write always ends its word.
	a_data_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.is_data) |-> result.last_write)
		else $error("data write not marked last");

	// A write that is not last is followed at once by another.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_write) |=> result_valid)
		else $error("refresh burst broken");

	// A data write comes right after a set-column command to the same half.
	a_col_before_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.is_data) |->
			($past(result_valid) && ($past(result.bus_byte[7:6]) == 2'b01) &&
			($past(result.chip_right) == result.chip_right)))
		else $error("data write without preceding set column");

endmodule

bind mono_framebuffer_page_refresh mfb_checker u_mfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
